>>> rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

  localparam int ARENA_UNITS_DEF = 4096;
  localparam int HDR_UNITS_DEF = 5;

  localparam int REQ_W = 16;
  localparam int OFF_W = 15;
  localparam int LIMIT_W = 13;
  localparam int UNITS_W = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] free_offset;
  } request_t;

  typedef struct packed {
    logic [OFF_W-1:0] payload_offset;
    logic             status;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/ffa_mem.sv
`default_nettype none
module ffa_mem #(
  parameter int ARENA_UNITS = ffa_pkg::ARENA_UNITS_DEF
) (
  input  wire                           clk,
  input  wire                           we_a,
  input  wire  [$clog2(ARENA_UNITS)-1:0] waddr_a,
  input  wire  [$clog2(ARENA_UNITS)+1:0] wdata_a,
  input  wire  [$clog2(ARENA_UNITS)-1:0] raddr_a,
  output logic [$clog2(ARENA_UNITS)+1:0] rdata_a,
  input  wire                           we_b,
  input  wire  [$clog2(ARENA_UNITS)-1:0] waddr_b,
  input  wire  [$clog2(ARENA_UNITS)-1:0] wdata_b,
  input  wire  [$clog2(ARENA_UNITS)-1:0] raddr_b,
  output logic [$clog2(ARENA_UNITS)-1:0] rdata_b
);

  localparam int AW = $clog2(ARENA_UNITS);

  // Entry of the size memory is the payload size and the used flag.
  logic [AW+1:0] size_mem [ARENA_UNITS];
  logic [AW-1:0] link_mem [ARENA_UNITS];

  always_ff @(posedge clk) begin
    if (we_a) begin
      size_mem[waddr_a] <= wdata_a;
    end
    rdata_a <= size_mem[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      link_mem[waddr_b] <= wdata_b;
    end
    rdata_b <= link_mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> rtl/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl #(
  parameter int ARENA_UNITS = ffa_pkg::ARENA_UNITS_DEF,
  parameter int HDR_UNITS = ffa_pkg::HDR_UNITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  ffa_pkg::request_t        request,
  input  wire  [ffa_pkg::LIMIT_W-1:0]    heap_limit,
  output logic                           done,
  output ffa_pkg::result_t               result,
  output logic                           we_a,
  output logic [$clog2(ARENA_UNITS)-1:0] waddr_a,
  output logic [$clog2(ARENA_UNITS)+1:0] wdata_a,
  output logic [$clog2(ARENA_UNITS)-1:0] raddr_a,
  input  wire  [$clog2(ARENA_UNITS)+1:0] rdata_a,
  output logic                           we_b,
  output logic [$clog2(ARENA_UNITS)-1:0] waddr_b,
  output logic [$clog2(ARENA_UNITS)-1:0] wdata_b,
  output logic [$clog2(ARENA_UNITS)-1:0] raddr_b,
  input  wire  [$clog2(ARENA_UNITS)-1:0] rdata_b
);

  localparam int AW = $clog2(ARENA_UNITS);
  localparam int UW = AW + 1;
  localparam int RW = ffa_pkg::UNITS_W;
  localparam int SW = ((UW > RW) ? UW : RW) + 2;
  localparam int OW = ffa_pkg::OFF_W;

  localparam logic [SW-1:0] HDR_W = SW'(HDR_UNITS);
  localparam logic [SW-1:0] HDR2_W = SW'(2 * HDR_UNITS);
  localparam logic [SW-1:0] ARENA_W = SW'(ARENA_UNITS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WALK   = 4'd1;
  localparam logic [3:0] S_SPLIT  = 4'd2;
  localparam logic [3:0] S_EXT    = 4'd3;
  localparam logic [3:0] S_FSTART = 4'd4;
  localparam logic [3:0] S_FWALK  = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FB     = 4'd7;
  localparam logic [3:0] S_FN     = 4'd8;
  localparam logic [3:0] S_FP     = 4'd9;
  localparam logic [3:0] S_FPW    = 4'd10;

  logic [3:0]       state, state_next;
  logic [UW-1:0]    cur, cur_next;
  logic [AW-1:0]    last, last_next;
  logic [RW-1:0]    units, units_next;
  logic [OW-1:0]    off, off_next;
  logic [UW-1:0]    pay_r, pay_r_next;
  logic [AW-1:0]    prev_r, prev_r_next;
  logic [AW-1:0]    aux, aux_next;
  logic [UW-1:0]    heap_end, heap_end_next;
  logic             done_next;
  ffa_pkg::result_t result_next;

  logic [RW+2:0] req_sum;
  logic [SW-1:0] rd_pay, cur_w, he_w, units_w, payr_w, b_w, lim_w;
  logic          rd_used, unit_low;
  logic [SW-1:0] nxt_rd, b_nxt, merged, b_merged_nxt, p_merged_nxt;
  logic [SW-1:0] nb, rem, split_nxt, ext_end, ofs_cur, ofs_he;
  logic          split_cond, ext_fail;

  assign req_sum = {1'b0, request.request_bytes} + (RW+3)'(7);
  assign rd_pay = SW'(rdata_a[UW:1]);
  assign rd_used = rdata_a[0];
  assign cur_w = SW'(cur);
  assign he_w = SW'(heap_end);
  assign units_w = SW'(units);
  assign payr_w = SW'(pay_r);
  assign unit_low = SW'(off[OW-1:3]) < HDR_W;
  assign b_w = SW'(off[OW-1:3]) - HDR_W;
  assign lim_w = (SW'(heap_limit) < ARENA_W) ? SW'(heap_limit) : ARENA_W;
  assign nxt_rd = cur_w + HDR_W + rd_pay;
  assign b_nxt = b_w + HDR_W + rd_pay;
  assign merged = payr_w + HDR_W + rd_pay;
  assign b_merged_nxt = b_w + HDR_W + merged;
  assign p_merged_nxt = SW'(prev_r) + HDR_W + merged;
  assign nb = cur_w + HDR_W + units_w;
  assign rem = rd_pay - units_w - HDR_W;
  assign split_cond = rd_pay > (units_w + HDR2_W);
  assign split_nxt = cur_w + HDR_W + payr_w;
  assign ext_end = he_w + HDR_W + units_w;
  assign ext_fail = (ext_end > lim_w) || ((he_w + HDR_W) >= ARENA_W);
  assign ofs_cur = cur_w + HDR_W;
  assign ofs_he = he_w + HDR_W;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cur_next = cur;
    last_next = last;
    units_next = units;
    off_next = off;
    pay_r_next = pay_r;
    prev_r_next = prev_r;
    aux_next = aux;
    heap_end_next = heap_end;
    done_next = 1'b0;
    result_next = result;
    we_a = 1'b0;
    waddr_a = cur[AW-1:0];
    wdata_a = {rd_pay[UW-1:0], 1'b0};
    raddr_a = '0;
    we_b = 1'b0;
    waddr_b = '0;
    wdata_b = '0;
    raddr_b = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          units_next = req_sum[RW+2:3];
          off_next = request.free_offset;
          cur_next = '0;
          last_next = '0;
          if (request.op == ffa_pkg::OP_FREE) begin
            state_next = S_FSTART;
          end else if (heap_end != '0) begin
            state_next = S_WALK;
          end else begin
            state_next = S_EXT;
          end
        end
      end
      S_WALK: begin
        if (!rd_used && (rd_pay >= units_w)) begin
          if (split_cond) begin
            we_a = 1'b1;
            waddr_a = nb[AW-1:0];
            wdata_a = {rem[UW-1:0], 1'b0};
            we_b = 1'b1;
            waddr_b = nb[AW-1:0];
            wdata_b = cur[AW-1:0];
            aux_next = nb[AW-1:0];
            pay_r_next = rd_pay[UW-1:0];
            state_next = S_SPLIT;
          end else begin
            we_a = 1'b1;
            waddr_a = cur[AW-1:0];
            wdata_a = {rd_pay[UW-1:0], 1'b1};
            done_next = 1'b1;
            result_next = '{payload_offset: {ofs_cur[11:0], 3'b000},
                            status: ffa_pkg::STATUS_OK};
            state_next = S_IDLE;
          end
        end else begin
          last_next = cur[AW-1:0];
          cur_next = nxt_rd[UW-1:0];
          if (nxt_rd < he_w) begin
            raddr_a = nxt_rd[AW-1:0];
          end else begin
            state_next = S_EXT;
          end
        end
      end
      S_SPLIT: begin
        we_a = 1'b1;
        waddr_a = cur[AW-1:0];
        wdata_a = {units_w[UW-1:0], 1'b1};
        if (split_nxt < he_w) begin
          we_b = 1'b1;
          waddr_b = split_nxt[AW-1:0];
          wdata_b = aux;
        end
        done_next = 1'b1;
        result_next = '{payload_offset: {ofs_cur[11:0], 3'b000},
                        status: ffa_pkg::STATUS_OK};
        state_next = S_IDLE;
      end
      S_EXT: begin
        done_next = 1'b1;
        state_next = S_IDLE;
        if (ext_fail) begin
          result_next = '{payload_offset: '0, status: ffa_pkg::STATUS_FAIL};
        end else begin
          we_a = 1'b1;
          waddr_a = heap_end[AW-1:0];
          wdata_a = {units_w[UW-1:0], 1'b1};
          we_b = 1'b1;
          waddr_b = heap_end[AW-1:0];
          wdata_b = last;
          heap_end_next = ext_end[UW-1:0];
          result_next = '{payload_offset: {ofs_he[11:0], 3'b000},
                          status: ffa_pkg::STATUS_OK};
        end
      end
      S_FSTART: begin
        if (unit_low) begin
          done_next = 1'b1;
          result_next = '{payload_offset: off, status: ffa_pkg::STATUS_OK};
          state_next = S_IDLE;
        end else if ((heap_end != '0) && (b_w != '0)) begin
          state_next = S_FWALK;
        end else begin
          state_next = S_FCHK;
        end
      end
      S_FWALK: begin
        cur_next = nxt_rd[UW-1:0];
        if ((nxt_rd < he_w) && (nxt_rd < b_w)) begin
          raddr_a = nxt_rd[AW-1:0];
        end else begin
          state_next = S_FCHK;
        end
      end
      S_FCHK: begin
        if ((cur_w != b_w) || (b_w >= he_w)) begin
          done_next = 1'b1;
          result_next = '{payload_offset: off, status: ffa_pkg::STATUS_OK};
          state_next = S_IDLE;
        end else begin
          raddr_a = b_w[AW-1:0];
          raddr_b = b_w[AW-1:0];
          state_next = S_FB;
        end
      end
      S_FB: begin
        we_a = 1'b1;
        waddr_a = b_w[AW-1:0];
        wdata_a = {rd_pay[UW-1:0], 1'b0};
        pay_r_next = rd_pay[UW-1:0];
        prev_r_next = rdata_b;
        if (b_nxt < he_w) begin
          raddr_a = b_nxt[AW-1:0];
          state_next = S_FN;
        end else begin
          state_next = S_FP;
        end
      end
      S_FN: begin
        if (!rd_used) begin
          pay_r_next = merged[UW-1:0];
          we_a = 1'b1;
          waddr_a = b_w[AW-1:0];
          wdata_a = {merged[UW-1:0], 1'b0};
          if (b_merged_nxt < he_w) begin
            we_b = 1'b1;
            waddr_b = b_merged_nxt[AW-1:0];
            wdata_b = b_w[AW-1:0];
          end
        end
        state_next = S_FP;
      end
      S_FP: begin
        if (b_w != '0) begin
          raddr_a = prev_r;
          state_next = S_FPW;
        end else begin
          done_next = 1'b1;
          result_next = '{payload_offset: off, status: ffa_pkg::STATUS_OK};
          state_next = S_IDLE;
        end
      end
      S_FPW: begin
        if (!rd_used) begin
          we_a = 1'b1;
          waddr_a = prev_r;
          wdata_a = {merged[UW-1:0], 1'b0};
          if (p_merged_nxt < he_w) begin
            we_b = 1'b1;
            waddr_b = p_merged_nxt[AW-1:0];
            wdata_b = prev_r;
          end
        end
        done_next = 1'b1;
        result_next = '{payload_offset: off, status: ffa_pkg::STATUS_OK};
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heap_end <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      heap_end <= heap_end_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    last <= last_next;
    units <= units_next;
    off <= off_next;
    pay_r <= pay_r_next;
    prev_r <= prev_r_next;
    aux <= aux_next;
    result <= result_next;
  end

endmodule
`default_nettype wire

>>> rtl/first_fit_heap_allocator.sv
`default_nettype none
// First-fit heap allocator over an arena of 8-byte units.
// A command is taken at a clock edge where start is high and busy is low.
// The request carries op (allocate or free), request_bytes and free_offset.
// Exactly one result beat follows each command: done is high for one cycle
// while result holds payload_offset and status. The receiver cannot stall,
// so a result is always taken in the cycle it appears.
// An allocate walks the block list with one memory read per block. When it
// takes a free block that fits, it marks that block used, first splitting
// off the rest as a new free block when the block is large enough; when no
// block fits, the heap is extended at its end if the limit allows.
// A free walks past the blocks before the freed one, then clears its used
// flag and merges it with a free next block and a free previous block. A
// new command can be taken in the cycle in which done is high.
// The walk over the size memory sets the rate.
// Reset empties the heap and sets heap_limit to 4096; the block memories
// need no clearing pass. heap_limit is written through the cfg channel,
// which is always ready, and must only be written while busy is low.
module first_fit_heap_allocator #(
  parameter int ARENA_UNITS = ffa_pkg::ARENA_UNITS_DEF,
  parameter int HDR_UNITS = ffa_pkg::HDR_UNITS_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire  ffa_pkg::request_t     request,
  output logic                        done,
  output ffa_pkg::result_t            result,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [ffa_pkg::LIMIT_W-1:0] cfg_data
);

  localparam int AW = $clog2(ARENA_UNITS);

  logic [ffa_pkg::LIMIT_W-1:0] heap_limit;
  logic                        we_a, we_b;
  logic [AW-1:0]               waddr_a, raddr_a, waddr_b, raddr_b, wdata_b, rdata_b;
  logic [AW+1:0]               wdata_a, rdata_a;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= ffa_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heap_limit <= cfg_data;
    end
  end

  ffa_ctrl #(
    .ARENA_UNITS(ARENA_UNITS),
    .HDR_UNITS(HDR_UNITS)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .heap_limit(heap_limit),
    .done(done),
    .result(result),
    .we_a(we_a),
    .waddr_a(waddr_a),
    .wdata_a(wdata_a),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .we_b(we_b),
    .waddr_b(waddr_b),
    .wdata_b(wdata_b),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  ffa_mem #(
    .ARENA_UNITS(ARENA_UNITS)
  ) u_mem (
    .clk(clk),
    .we_a(we_a),
    .waddr_a(waddr_a),
    .wdata_a(wdata_a),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .we_b(we_b),
    .waddr_b(waddr_b),
    .wdata_b(wdata_b),
    .raddr_b(raddr_b),
    .rdata_b(rdata_b)
  );

  // A result beat only ever follows a cycle of work on a command.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a command in progress");

  // No command finishes in the cycle right after it is taken.
  a_no_instant_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result beat one cycle after accept");

  // Every command that ends delivers its result beat.
  a_fell_busy_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("command ended without a result beat");

  // A failed allocate reports a zero offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == ffa_pkg::STATUS_FAIL)) |-> (result.payload_offset == '0))
    else $error("failed allocate with nonzero offset");

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import ffa_pkg::*;

  localparam int ARENA = ARENA_UNITS_DEF;
  localparam int HDR = HDR_UNITS_DEF;

  typedef enum logic {KIND_PLAIN, KIND_FREE_LIVE} cmd_kind_t;

  typedef struct {
    cmd_kind_t kind;
    request_t  req;
  } pend_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  request_t cmd_req = '0;
  logic cfg_valid = 1'b0;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic busy;
  logic done;
  logic cfg_ready;
  result_t result;

  bit [12:0] blk_units [ARENA];
  bit blk_used [ARENA];
  bit [11:0] blk_prev [ARENA];
  int unsigned heap_end_m = 0;
  logic [LIMIT_W-1:0] limit_m = LIMIT_RESET;

  pend_cmd_t cmd_queue[$];
  result_t expected_results[$];
  logic [OFF_W-1:0] live_offsets[$];
  int gap_left = 0;
  int burst_left = 0;
  int mismatches = 0;

  first_fit_heap_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(cmd_req),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned heap_next(input int unsigned s);
    return s + HDR + blk_units[s];
  endfunction

  function automatic void heap_relink(input int unsigned s);
    int unsigned n;
    n = heap_next(s);
    if (n < heap_end_m && n < ARENA) blk_prev[n] = 12'(s);
  endfunction

  function automatic void heap_merge_next(input int unsigned s);
    int unsigned n;
    n = heap_next(s);
    blk_units[s] = 13'(blk_units[s] + HDR + blk_units[n]);
    heap_relink(s);
  endfunction

  function automatic result_t heap_alloc(input logic [REQ_W-1:0] nbytes);
    int unsigned units, cur, last, lim, nb, st, fin;
    result_t r;
    units = nbytes;
    units = (units + 7) >> 3;
    cur = 0;
    last = 0;
    r = '0;
    while (cur < heap_end_m && cur < ARENA) begin
      if (!blk_used[cur] && blk_units[cur] >= units) begin
        if (blk_units[cur] > units + 2 * HDR) begin
          nb = cur + HDR + units;
          blk_units[nb] = 13'(blk_units[cur] - units - HDR);
          blk_used[nb] = 1'b0;
          blk_prev[nb] = 12'(cur);
          blk_units[cur] = 13'(units);
          heap_relink(nb);
        end
        blk_used[cur] = 1'b1;
        r.payload_offset = OFF_W'((cur + HDR) << 3);
        r.status = STATUS_OK;
        return r;
      end
      last = cur;
      cur = heap_next(cur);
    end
    lim = (limit_m < ARENA) ? limit_m : ARENA;
    st = heap_end_m;
    fin = st + HDR + units;
    if (fin > lim || st + HDR >= ARENA) begin
      r.status = STATUS_FAIL;
      return r;
    end
    blk_units[st] = 13'(units);
    blk_used[st] = 1'b1;
    blk_prev[st] = 12'(last);
    heap_end_m = fin;
    r.payload_offset = OFF_W'((st + HDR) << 3);
    r.status = STATUS_OK;
    return r;
  endfunction

  function automatic void heap_free(input logic [OFF_W-1:0] offset);
    int unsigned unit, b, cur, n, p;
    unit = offset >> 3;
    if (unit < HDR) return;
    b = unit - HDR;
    cur = 0;
    while (cur < heap_end_m && cur < b) cur = heap_next(cur);
    if (cur != b || b >= heap_end_m || b >= ARENA) return;
    blk_used[b] = 1'b0;
    n = heap_next(b);
    if (n < heap_end_m && n < ARENA && !blk_used[n]) heap_merge_next(b);
    if (b != 0) begin
      p = blk_prev[b];
      if (!blk_used[p]) heap_merge_next(p);
    end
  endfunction

  function automatic int first_hole_units();
    int unsigned cur;
    cur = 0;
    while (cur < heap_end_m) begin
      if (!blk_used[cur]) return blk_units[cur];
      cur = heap_next(cur);
    end
    return -1;
  endfunction

  function automatic void apply_command(input request_t r);
    result_t res;
    if (r.op == OP_ALLOC) begin
      res = heap_alloc(r.request_bytes);
      if (res.status == STATUS_OK) live_offsets.push_back(res.payload_offset);
    end else begin
      heap_free(r.free_offset);
      for (int i = live_offsets.size() - 1; i >= 0; i--) begin
        if (live_offsets[i][OFF_W-1:3] == r.free_offset[OFF_W-1:3]) live_offsets.delete(i);
      end
      res.payload_offset = r.free_offset;
      res.status = STATUS_OK;
    end
    expected_results.push_back(res);
  endfunction

  function automatic void queue_cmd(input cmd_kind_t k, input logic op,
                                    input logic [REQ_W-1:0] nbytes,
                                    input logic [OFF_W-1:0] offset);
    pend_cmd_t c;
    c.kind = k;
    c.req.op = op;
    c.req.request_bytes = nbytes;
    c.req.free_offset = offset;
    cmd_queue.push_back(c);
  endfunction

  function automatic pend_cmd_t random_cmd();
    pend_cmd_t c;
    int sel, sz;
    c.kind = KIND_PLAIN;
    c.req.request_bytes = REQ_W'($urandom);
    c.req.free_offset = OFF_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 52) begin
      c.req.op = OP_ALLOC;
      sz = $urandom_range(0, 99);
      if (sz < 8) c.req.request_bytes = '0;
      else if (sz < 66) c.req.request_bytes = REQ_W'($urandom_range(1, 128));
      else if (sz < 90) c.req.request_bytes = REQ_W'($urandom_range(129, 1024));
      else if (sz < 97) c.req.request_bytes = REQ_W'($urandom_range(1025, 8000));
    end else begin
      c.req.op = OP_FREE;
      if (sel < 92) c.kind = KIND_FREE_LIVE;
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int s;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    s = $urandom_range(0, 99);
    if (s < 3) burst_left = $urandom_range(20, 60);
    if (s < 45) return 0;
    if (s < 85) return $urandom_range(1, 3);
    if (s < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // A command is predicted at the edge where it is accepted; free commands
  // aimed at live blocks pick their target when they are put on the port.
  always @(posedge clk) begin
    pend_cmd_t nxt;
    request_t req;
    int idx;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (start) apply_command(cmd_req);
      if (gap_left > 0 || cmd_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        start <= 1'b0;
      end else begin
        nxt = cmd_queue.pop_front();
        req = nxt.req;
        if (nxt.kind == KIND_FREE_LIVE && live_offsets.size() != 0) begin
          idx = $urandom_range(0, live_offsets.size() - 1);
          req.free_offset = live_offsets[idx] | OFF_W'($urandom_range(0, 7));
        end
        cmd_req <= req;
        start <= 1'b1;
        gap_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat offset=%0d status=%0d",
                                  result.payload_offset, result.status));
      end else begin
        want = expected_results.pop_front();
        if (result.payload_offset !== want.payload_offset)
          report_mismatch($sformatf("payload_offset got %0d want %0d",
                                    result.payload_offset, want.payload_offset));
        if (result.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    result.status, want.status));
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (cmd_queue.size() != 0 || start || busy || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    limit_m = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) cmd_queue.push_back(random_cmd());
    wait_idle();
  endtask

  initial begin
    int units, tries;
    int phase_limit [5];
    int phase_count [5];
    phase_limit = '{1, 400, 1500, 4000, 2000};
    phase_count = '{60, 200, 200, 300, 100};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd0, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd1, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd8, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd9, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd65535, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd32768, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd0);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd32767);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd133);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd128);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd80);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd40);
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd16, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd40);
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd8, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd176);
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd200, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd384);
    queue_cmd(KIND_PLAIN, OP_FREE, REQ_W'($urandom), 15'd472);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_limit(LIMIT_W'(phase_limit[p]));
      run_random(phase_count[p]);
    end

    // Close every hole, then grow the heap to exactly the end of the arena, so
    // that the next header would lie past it.
    write_limit(13'd8191);
    tries = 0;
    units = first_hole_units();
    while (units >= 0 && tries < 400) begin
      queue_cmd(KIND_PLAIN, OP_ALLOC, REQ_W'(units * 8), OFF_W'($urandom));
      wait_idle();
      tries++;
      units = first_hole_units();
    end
    if (heap_end_m + 2 * HDR <= ARENA) begin
      units = ARENA - HDR - heap_end_m + 1;
      queue_cmd(KIND_PLAIN, OP_ALLOC, REQ_W'(units * 8), OFF_W'($urandom));
      queue_cmd(KIND_PLAIN, OP_ALLOC, REQ_W'((units - 1) * 8), OFF_W'($urandom));
      wait_idle();
    end
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd0, OFF_W'($urandom));
    queue_cmd(KIND_PLAIN, OP_ALLOC, 16'd0, OFF_W'($urandom));
    wait_idle();
    run_random(80);

    write_limit(LIMIT_RESET);
    run_random(80);

    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
